// ----- hw/rtl/kvs_pkg.sv -----
// kvs_pkg: shared types and codes for the keyframe vector sampler
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package kvs_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 17;

  typedef logic [1:0] action_t;
  typedef logic [1:0] status_t;

  localparam action_t ACT_APPEND = 2'd0;
  localparam action_t ACT_CLEAR  = 2'd1;
  localparam action_t ACT_SAMPLE = 2'd2;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  typedef struct packed {
    logic [DATA_W-1:0] t;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
  } key_entry_t;

  typedef struct packed {
    logic             start;
    logic [DATA_W-1:0] num;
    logic [DATA_W-1:0] den;
  } div_req_t;

endpackage

// ----- hw/rtl/kvs_frac_div.sv -----
// kvs_frac_div: restoring divider, one quotient bit per cycle
// gives floor(num * 2^16 / den) for num <= den; depends on kvs_pkg
`timescale 1ns / 1ps

module kvs_frac_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  kvs_pkg::div_req_t         req,
  output logic                      done,
  output logic [kvs_pkg::FRAC_W-1:0] quot
);
  import kvs_pkg::*;

  localparam int CNT_W = $clog2(FRAC_W);

  logic                busy_r;
  logic                done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [DATA_W:0]     rem_r;
  logic [DATA_W-1:0]   den_r;
  logic [FRAC_W-1:0]   quot_r;
  logic                ge;
  logic [DATA_W:0]     rem_sub;

  assign ge      = rem_r >= {1'b0, den_r};
  assign rem_sub = ge ? (rem_r - {1'b0, den_r}) : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(FRAC_W - 1);
        rem_r  <= {1'b0, req.num};
        den_r  <= req.den;
      end else if (busy_r) begin
        rem_r  <= {rem_sub[DATA_W-1:0], 1'b0};
        quot_r <= {quot_r[FRAC_W-2:0], ge};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ----- hw/rtl/kvs_lerp.sv -----
// kvs_lerp: shared multiply-add for one vector component at a time
// v0 + floor((v1 - v0) * f / 2^16); depends on kvs_pkg
`timescale 1ns / 1ps

module kvs_lerp (
  input  logic                       clk,
  input  logic                       load,
  input  logic [kvs_pkg::DATA_W-1:0] v0,
  input  logic [kvs_pkg::DATA_W-1:0] v1,
  input  logic [kvs_pkg::FRAC_W-1:0] frac,
  output logic [kvs_pkg::DATA_W-1:0] result
);
  import kvs_pkg::*;

  localparam int PROD_W = DATA_W + FRAC_W + 2;

  logic signed [DATA_W:0]   diff;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic [DATA_W-1:0]        v0_r;

  assign diff     = $signed({v1[DATA_W-1], v1}) - $signed({v0[DATA_W-1], v0});
  assign prod_nxt = diff * $signed({1'b0, frac});

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
      v0_r   <= v0;
    end
  end

  // arithmetic shift by 16 is floor division; low word is enough
  assign result = v0_r + prod_r[DATA_W+15:16];

endmodule

// ----- hw/rtl/keyframe_vector_sampler.sv -----
// keyframe_vector_sampler: keyframe table with piecewise-linear sampling
// uses kvs_pkg, kvs_frac_div and kvs_lerp
//
//   channel | direction | ports
//   in      | input     | in_valid, in_stall, in_action, in_load_*, in_sample_time
//   out     | output    | out_valid, out_stall, out_x, out_y, out_z, out_status
//
// append, clear and unused codes: result in the cycle after the transfer
// sample: keys are scanned one at a time (one table read port), then a
//   fraction divide and a multiply-add for each of x, y and z
// one item at a time; in_stall is high while a sample is in work or a result waits
// reset clears the key count and out_valid; result data and table entries are not cleared
`timescale 1ns / 1ps

module keyframe_vector_sampler #(
  parameter int MAX_KEYS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_action,
  input  logic [kvs_pkg::DATA_W-1:0]  in_load_time,
  input  logic [kvs_pkg::DATA_W-1:0]  in_load_x,
  input  logic [kvs_pkg::DATA_W-1:0]  in_load_y,
  input  logic [kvs_pkg::DATA_W-1:0]  in_load_z,
  input  logic [kvs_pkg::DATA_W-1:0]  in_sample_time,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [kvs_pkg::DATA_W-1:0]  out_x,
  output logic [kvs_pkg::DATA_W-1:0]  out_y,
  output logic [kvs_pkg::DATA_W-1:0]  out_z,
  output logic [1:0]                  out_status
);
  import kvs_pkg::*;

  localparam int AW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_WAIT0, S_CHK0, S_WAITN, S_CHKN, S_DIV, S_MUL, S_ADD
  } state_t;

  typedef enum logic [1:0] {C_X, C_Y, C_Z} comp_t;

  state_t             state_r;
  comp_t              comp_r;
  logic [CW-1:0]      count_r;
  logic [AW-1:0]      idx_r;
  logic [DATA_W-1:0]  s_r;
  key_entry_t         prev_r;
  key_entry_t         cur_r;
  key_entry_t         rdata_r;
  key_entry_t         mem [MAX_KEYS];

  logic               out_valid_r;
  logic [DATA_W-1:0]  out_x_r, out_y_r, out_z_r;
  status_t            out_status_r;

  logic               in_xfer;
  logic               wr_en;
  logic               bracket;
  logic               is_last;
  div_req_t           div_req;
  logic               div_done;
  logic [FRAC_W-1:0]  frac;
  logic [DATA_W-1:0]  lerp_v0, lerp_v1, lerp_res;

  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_xfer  = in_valid && !in_stall;
  assign wr_en    = in_xfer && (in_action == ACT_APPEND) && (count_r < CW'(MAX_KEYS));

  // key table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= '{t: in_load_time, x: in_load_x, y: in_load_y, z: in_load_z};
    end
    rdata_r <= mem[idx_r];
  end

  assign bracket = (prev_r.t <= s_r) && (s_r <= rdata_r.t);
  assign is_last = (CW'(idx_r) + CW'(1)) == count_r;

  assign div_req.start = (state_r == S_CHKN) && bracket && (prev_r.t != rdata_r.t);
  assign div_req.num   = s_r - prev_r.t;
  assign div_req.den   = rdata_r.t - prev_r.t;

  kvs_frac_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (frac)
  );

  always_comb begin
    unique case (comp_r)
      C_X:     begin lerp_v0 = prev_r.x; lerp_v1 = cur_r.x; end
      C_Y:     begin lerp_v0 = prev_r.y; lerp_v1 = cur_r.y; end
      C_Z:     begin lerp_v0 = prev_r.z; lerp_v1 = cur_r.z; end
      default: begin lerp_v0 = prev_r.x; lerp_v1 = cur_r.x; end
    endcase
  end

  kvs_lerp u_lerp (
    .clk    (clk),
    .load   (state_r == S_MUL),
    .v0     (lerp_v0),
    .v1     (lerp_v1),
    .frac   (frac),
    .result (lerp_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      comp_r      <= C_X;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            out_x_r      <= '0;
            out_y_r      <= '0;
            out_z_r      <= '0;
            out_status_r <= ST_OK;
            s_r          <= in_sample_time;
            idx_r        <= '0;
            unique case (in_action)
              ACT_APPEND: begin
                out_valid_r <= 1'b1;
                if (wr_en) begin
                  count_r <= count_r + 1'b1;
                end else begin
                  out_status_r <= ST_FULL;
                end
              end
              ACT_CLEAR: begin
                out_valid_r <= 1'b1;
                count_r     <= '0;
              end
              ACT_SAMPLE: begin
                if (count_r == '0) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= ST_EMPTY;
                end else begin
                  state_r <= S_WAIT0;
                end
              end
              default: begin
                out_valid_r <= 1'b1;
              end
            endcase
          end
        end
        S_WAIT0: begin
          state_r <= S_CHK0;
        end
        S_CHK0: begin
          prev_r <= rdata_r;
          if (count_r == CW'(1) || s_r <= rdata_r.t) begin
            out_x_r     <= rdata_r.x;
            out_y_r     <= rdata_r.y;
            out_z_r     <= rdata_r.z;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            idx_r   <= AW'(1);
            state_r <= S_WAITN;
          end
        end
        S_WAITN: begin
          state_r <= S_CHKN;
        end
        S_CHKN: begin
          cur_r <= rdata_r;
          if (bracket) begin
            if (prev_r.t == rdata_r.t) begin
              out_x_r     <= prev_r.x;
              out_y_r     <= prev_r.y;
              out_z_r     <= prev_r.z;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              comp_r  <= C_X;
              state_r <= S_DIV;
            end
          end else if (is_last) begin
            out_x_r     <= rdata_r.x;
            out_y_r     <= rdata_r.y;
            out_z_r     <= rdata_r.z;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            prev_r  <= rdata_r;
            idx_r   <= idx_r + 1'b1;
            state_r <= S_WAITN;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          state_r <= S_ADD;
        end
        S_ADD: begin
          unique case (comp_r)
            C_X: begin
              out_x_r <= lerp_res;
              comp_r  <= C_Y;
              state_r <= S_MUL;
            end
            C_Y: begin
              out_y_r <= lerp_res;
              comp_r  <= C_Z;
              state_r <= S_MUL;
            end
            default: begin
              out_z_r     <= lerp_res;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          endcase
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_x      = out_x_r;
  assign out_y      = out_y_r;
  assign out_z      = out_z_r;
  assign out_status = out_status_r;

endmodule

// ----- hw/rtl/kvs_checker.sv -----
// kvs_checker: port-level checks for keyframe_vector_sampler
// bound to the top level below; depends on kvs_pkg
`timescale 1ns / 1ps

module kvs_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [kvs_pkg::DATA_W-1:0] out_x,
  input logic [kvs_pkg::DATA_W-1:0] out_y,
  input logic [kvs_pkg::DATA_W-1:0] out_z,
  input logic [1:0]                 out_status
);
  import kvs_pkg::*;

  // no new item while a result is held back
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_EMPTY || out_status == ST_FULL))
    else $error("bad status code");

  // error results carry a zero vector
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_x == '0 && out_y == '0 && out_z == '0)
    else $error("error result with nonzero vector");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_x) && $stable(out_y) && $stable(out_z)
      && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind keyframe_vector_sampler kvs_checker u_kvs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_x      (out_x),
  .out_y      (out_y),
  .out_z      (out_z),
  .out_status (out_status)
);

// ----- sim/keyframe_vector_sampler_tb.sv -----
// keyframe_vector_sampler_tb: self-checking bench for the keyframe vector sampler
// random and directed append, clear and sample transfers checked against a built-in predictor
// depends on kvs_pkg and keyframe_vector_sampler
`timescale 1ns / 1ps

module keyframe_vector_sampler_tb;
  import kvs_pkg::*;

  localparam int MAX_KEYS = 32;
  localparam int PHASE_ITEMS = 550;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 100;
  localparam action_t ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic              drain;
    int                phase;
    action_t           act;
    logic [DATA_W-1:0] load_time;
    logic [DATA_W-1:0] load_x;
    logic [DATA_W-1:0] load_y;
    logic [DATA_W-1:0] load_z;
    logic [DATA_W-1:0] sample_time;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
    status_t           status;
  } result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_action = '0;
  logic [DATA_W-1:0] in_load_time = '0;
  logic [DATA_W-1:0] in_load_x = '0;
  logic [DATA_W-1:0] in_load_y = '0;
  logic [DATA_W-1:0] in_load_z = '0;
  logic [DATA_W-1:0] in_sample_time = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DATA_W-1:0] out_x;
  logic [DATA_W-1:0] out_y;
  logic [DATA_W-1:0] out_z;
  logic [1:0]        out_status;

  item_t             item_q[$];
  result_t           result_q[$];
  logic [DATA_W-1:0] stim_times[$];
  int                gen_phase = 0;
  int                phase_items = 0;
  int                cur_phase = 0;
  logic              in_taken = 1'b0;
  int                mismatch_count = 0;
  int                quiet_cycles = 0;

  // predictor copy of the keyframe table
  logic [DATA_W-1:0] knot_time[MAX_KEYS];
  logic [DATA_W-1:0] knot_x[MAX_KEYS];
  logic [DATA_W-1:0] knot_y[MAX_KEYS];
  logic [DATA_W-1:0] knot_z[MAX_KEYS];
  int unsigned       knot_count = 0;

  keyframe_vector_sampler #(
    .MAX_KEYS(MAX_KEYS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_load_time(in_load_time),
    .in_load_x(in_load_x),
    .in_load_y(in_load_y),
    .in_load_z(in_load_z),
    .in_sample_time(in_sample_time),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_x(out_x),
    .out_y(out_y),
    .out_z(out_z),
    .out_status(out_status)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // v0 + floor((v1 - v0) * f / 65536)
  function automatic logic [DATA_W-1:0] blend_component(logic [DATA_W-1:0] a,
                                                        logic [DATA_W-1:0] b,
                                                        logic [FRAC_W-1:0] f);
    longint v0;
    longint diff;
    longint prod;
    v0 = longint'(signed'(a));
    diff = longint'(signed'(b)) - v0;
    prod = diff * longint'(f);
    return DATA_W'(v0 + (prod >>> 16));
  endfunction

  function automatic result_t predict_item(action_t act, logic [DATA_W-1:0] lt,
                                           logic [DATA_W-1:0] lx, logic [DATA_W-1:0] ly,
                                           logic [DATA_W-1:0] lz, logic [DATA_W-1:0] st);
    result_t           r;
    logic [63:0]       num;
    logic [63:0]       den;
    logic [FRAC_W-1:0] f;
    bit                found;
    r = '0;
    found = 1'b0;
    case (act)
      ACT_APPEND: begin
        if (knot_count >= MAX_KEYS) begin
          r.status = ST_FULL;
        end else begin
          knot_time[knot_count] = lt;
          knot_x[knot_count] = lx;
          knot_y[knot_count] = ly;
          knot_z[knot_count] = lz;
          knot_count++;
        end
      end
      ACT_CLEAR: knot_count = 0;
      ACT_SAMPLE: begin
        if (knot_count == 0) begin
          r.status = ST_EMPTY;
        end else if (knot_count == 1 || st <= knot_time[0]) begin
          r = '{knot_x[0], knot_y[0], knot_z[0], ST_OK};
        end else begin
          for (int i = 0; i + 1 < knot_count && !found; i++) begin
            if (knot_time[i] <= st && st <= knot_time[i+1]) begin
              found = 1'b1;
              if (knot_time[i] == knot_time[i+1]) begin
                r = '{knot_x[i], knot_y[i], knot_z[i], ST_OK};
              end else begin
                num = {32'd0, st - knot_time[i]} << 16;
                den = {32'd0, knot_time[i+1] - knot_time[i]};
                f = FRAC_W'(num / den);
                r.x = blend_component(knot_x[i], knot_x[i+1], f);
                r.y = blend_component(knot_y[i], knot_y[i+1], f);
                r.z = blend_component(knot_z[i], knot_z[i+1], f);
                r.status = ST_OK;
              end
            end
          end
          if (!found) begin
            r = '{knot_x[knot_count-1], knot_y[knot_count-1], knot_z[knot_count-1], ST_OK};
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int unsigned idle_pct(int ph, bit receiver);
    case (ph)
      0: return receiver ? 70 : 23;
      1: return receiver ? 23 : 70;
      default: return 0;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4, 5: return 32'($urandom_range(2000)) - 32'd1000;
      default: return $urandom;
    endcase
  endfunction

  // sample times aimed at the keys the generator has loaded so far
  function automatic logic [DATA_W-1:0] pick_sample_time();
    int unsigned       n;
    int unsigned       i;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    n = stim_times.size();
    if (n == 0) return $urandom;
    i = $urandom_range(n - 1);
    case ($urandom_range(5))
      0: return $urandom_range(stim_times[0]);
      1: return stim_times[i];
      2, 3: begin
        if (n < 2) return stim_times[0];
        i = $urandom_range(n - 2);
        lo = stim_times[i];
        hi = stim_times[i+1];
        if (hi < lo) return $urandom;
        return lo + 32'(64'($urandom) % (64'(hi - lo) + 64'd1));
      end
      4: begin
        hi = stim_times[n-1];
        if (hi == '1) return hi;
        return hi + 32'd1 + 32'(64'($urandom) % 64'(~hi));
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic push_item(action_t act, logic [DATA_W-1:0] lt, logic [DATA_W-1:0] lx,
                           logic [DATA_W-1:0] ly, logic [DATA_W-1:0] lz,
                           logic [DATA_W-1:0] st);
    item_t it;
    it = '0;
    it.phase = gen_phase;
    it.act = act;
    it.load_time = lt;
    it.load_x = lx;
    it.load_y = ly;
    it.load_z = lz;
    it.sample_time = st;
    item_q.push_back(it);
    if (act == ACT_APPEND && stim_times.size() < MAX_KEYS) stim_times.push_back(lt);
    else if (act == ACT_CLEAR) stim_times.delete();
    if (act != ACT_UNUSED) phase_items++;
  endtask

  // clear, a run of keys in nondecreasing time, then samples along the curve
  task automatic push_curve();
    int unsigned n;
    int unsigned r;
    logic [32:0] t;
    r = $urandom_range(9);
    if (r < 7) n = $urandom_range(6, 1);
    else if (r < 9) n = $urandom_range(31, 7);
    else n = $urandom_range(35, 32);
    push_item(ACT_CLEAR, $urandom, rand_word(), rand_word(), rand_word(), $urandom);
    t = $urandom_range(1) ? 33'($urandom_range(1000)) : 33'($urandom);
    for (int k = 0; k < n; k++) begin
      push_item(ACT_APPEND, t[31:0], rand_word(), rand_word(), rand_word(), $urandom);
      case ($urandom_range(7))
        0: ;
        1, 2, 3: t = t + 33'($urandom_range(100));
        4, 5: t = t + 33'($urandom_range(1 << 20));
        default: t = t + 33'($urandom);
      endcase
      if (t > 33'h0_ffff_ffff) t = 33'h0_ffff_ffff;
    end
    repeat ($urandom_range(8, 1)) begin
      push_item(ACT_SAMPLE, $urandom, rand_word(), rand_word(), rand_word(),
                pick_sample_time());
    end
  endtask

  // arbitrary actions: out-of-order keys, empty samples, unused code
  task automatic push_noise();
    repeat ($urandom_range(6, 1)) begin
      push_item(action_t'($urandom_range(3)), $urandom, rand_word(), rand_word(),
                rand_word(), $urandom_range(1) ? pick_sample_time() : $urandom);
    end
  endtask

  task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t ns: %s expected %h, actual %h", $time, name, want, got);
    end
  endtask

  initial begin
    item_t barrier;
    barrier = '0;
    barrier.drain = 1'b1;
    for (int ph = 0; ph < 3; ph++) begin
      gen_phase = ph;
      phase_items = 0;
      barrier.phase = ph;
      item_q.push_back(barrier);
      if (ph == 0) begin
        push_item(ACT_SAMPLE, '0, '0, '0, '0, 32'h0000_0000);
        push_item(ACT_SAMPLE, '1, '1, '1, '1, 32'hffff_ffff);
        push_item(ACT_UNUSED, '1, '1, '1, '1, '1);
        push_item(ACT_APPEND, 32'h80, 32'h7fff_ffff, 32'h8000_0000, 32'h0, '0);
        push_item(ACT_SAMPLE, '0, '0, '0, '0, 32'h0000_0000);
        push_item(ACT_SAMPLE, '0, '0, '0, '0, 32'hffff_ffff);
        push_item(ACT_APPEND, 32'h80, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, '0);
        push_item(ACT_APPEND, 32'hffff_ffff, 32'h0, 32'h1, 32'h8000_0000, '0);
        push_item(ACT_SAMPLE, '0, '0, '0, '0, 32'h80);
        push_item(ACT_SAMPLE, '0, '0, '0, '0, 32'h81);
        push_item(ACT_SAMPLE, '0, '0, '0, '0, 32'h7fff_ffff);
        push_item(ACT_SAMPLE, '0, '0, '0, '0, 32'hffff_fffe);
        push_item(ACT_SAMPLE, '0, '0, '0, '0, 32'hffff_ffff);
        push_item(ACT_CLEAR, '0, '0, '0, '0, '0);
        push_item(ACT_SAMPLE, '0, '0, '0, '0, 32'd5);
        push_item(ACT_APPEND, 32'd100, 32'h0001_0000, 32'hffff_0000, 32'd7, '0);
        push_item(ACT_APPEND, 32'd50, 32'h0005_0000, 32'h0002_0000, 32'hffff_fff9, '0);
        push_item(ACT_APPEND, 32'd60, 32'hfffb_0000, 32'h0003_0000, 32'd12345, '0);
        push_item(ACT_SAMPLE, '0, '0, '0, '0, 32'd200);
        push_item(ACT_SAMPLE, '0, '0, '0, '0, 32'd55);
        push_item(ACT_SAMPLE, '0, '0, '0, '0, 32'd70);
        push_item(ACT_CLEAR, '0, '0, '0, '0, '0);
      end
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(9) < 8) push_curve();
        else push_noise();
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (!(item_q.size() == 0 && !in_valid && result_q.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && result_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // input driver: one item in flight, held stable until its transfer
  always @(negedge clk) begin : drive_proc
    item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (item_q.size() > 0 && item_q[0].drain) begin
          in_valid <= 1'b0;
          if (result_q.size() == 0) void'(item_q.pop_front());
        end else if (item_q.size() > 0 &&
                     $urandom_range(99) >= idle_pct(item_q[0].phase, 1'b0)) begin
          it = item_q.pop_front();
          in_action <= it.act;
          in_load_time <= it.load_time;
          in_load_x <= it.load_x;
          in_load_y <= it.load_y;
          in_load_z <= it.load_z;
          in_sample_time <= it.sample_time;
          in_valid <= 1'b1;
          cur_phase <= it.phase;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < idle_pct(cur_phase, 1'b1));
    end
  end

  // predictor on input transfers, comparison on result transfers
  always @(posedge clk) begin : check_proc
    result_t want;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      result_q.push_back(predict_item(in_action, in_load_time, in_load_x, in_load_y,
                                      in_load_z, in_sample_time));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: result expected none, actual x %h y %h z %h status %0d",
                 $time, out_x, out_y, out_z, out_status);
      end else begin
        want = result_q.pop_front();
        check_field("x", want.x, out_x);
        check_field("y", want.y, out_y);
        check_field("z", want.z, out_z);
        check_field("status", 32'(want.status), 32'(out_status));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ----- keyframe_vector_sampler.f -----
hw/rtl/kvs_pkg.sv
hw/rtl/kvs_frac_div.sv
hw/rtl/kvs_lerp.sv
hw/rtl/keyframe_vector_sampler.sv
hw/rtl/kvs_checker.sv
sim/keyframe_vector_sampler_tb.sv
